### rtl/mnhp_pkg.sv
package mnhp_pkg;

	localparam int LENGTH_FIELD_BYTES = 4;
	localparam int LEN_CNT_W = 2;
	localparam logic [LEN_CNT_W-1:0] LEN_CNT_LAST = LEN_CNT_W'(LENGTH_FIELD_BYTES - 1);

	localparam logic [31:0] MARKER_MDAT = {8'h6D, 8'h64, 8'h61, 8'h74}; // "mdat"
	localparam logic [7:0] UNITS_MAX = 8'hFF;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_LENGTH,
		PH_HEADER,
		PH_SKIP,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic [31:0] nal_length;
		logic        forbidden_bit;
		logic [1:0]  ref_idc;
		logic [4:0]  unit_type;
	} nal_hdr_t;

endpackage

### rtl/mnhp_ifs.sv
interface mnhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface mnhp_hdr_if;
	logic        valid;
	logic        ready;
	logic [31:0] nal_length;
	logic        forbidden_bit;
	logic [1:0]  ref_idc;
	logic [4:0]  unit_type;

	modport source (output valid, output nal_length, output forbidden_bit,
		output ref_idc, output unit_type, input ready);
	modport sink (input valid, input nal_length, input forbidden_bit,
		input ref_idc, input unit_type, output ready);
endinterface

### rtl/mdat_nal_unit_header_parser_top.sv
// mdat NAL unit header parser.
// byte_ch (sink): one file byte per word, valid/ready handshake.
// hdr_ch (source): one word per NAL header: length prefix, forbidden bit,
//   ref_idc and unit type of the header byte.
// cfg_wr_en/cfg_wr_data: writes nal_limit (reset 3, 0 = unlimited); write it
//   only while the parser is quiet.
// Operation: bytes shift through a 4-byte window until "mdat" shows up, then
//   the stream is read as 4-byte big-endian length, header byte, payload.
//   Payload bytes are consumed and dropped. After nal_limit headers all
//   further bytes are accepted and discarded until reset.
// Path: a header byte is registered in the input register, then parsed and
//   loaded into the output register once it is free, which drives hdr_ch.
// Throughput: one byte per cycle unless a header byte stalls; the parser
//   state update is a short compare/shift/decrement per byte.
// Stall: the output register holds a word until taken. While it is full and
//   not being taken, a header byte waits in the input register and byte_ch
//   ready drops; non-header bytes keep flowing.
// Reset (arst_n low, async): parser back to marker search, no words pending,
//   nal_limit = 3.
module mdat_nal_unit_header_parser_top
	import mnhp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data,
	mnhp_byte_if.sink       byte_ch,
	mnhp_hdr_if.source      hdr_ch
);

	logic [7:0] nal_limit_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// output register
	logic       out_valid_q;
	nal_hdr_t   out_q;

	logic       emit;
	nal_hdr_t   result;
	logic       slot_free;
	logic       advance;
	logic       load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nal_limit_q <= 8'd3;
		end else if (cfg_wr_en) begin
			nal_limit_q <= cfg_wr_data;
		end
	end

	// Output slot frees up in the same cycle it is being taken.
	assign slot_free = !out_valid_q || hdr_ch.ready;
	// A byte that yields no word never waits for the output side.
	assign advance   = valid_s1 && (!emit || slot_free);
	assign load_out  = advance && emit;

	assign byte_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.data_byte;
		end
	end

	mnhp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.nal_limit (nal_limit_q),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (hdr_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	assign hdr_ch.valid         = out_valid_q;
	assign hdr_ch.nal_length    = out_q.nal_length;
	assign hdr_ch.forbidden_bit = out_q.forbidden_bit;
	assign hdr_ch.ref_idc       = out_q.ref_idc;
	assign hdr_ch.unit_type     = out_q.unit_type;

endmodule

### rtl/mnhp_parser.sv
module mnhp_parser
	import mnhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic [7:0] nal_limit,
	output logic       emit,
	output nal_hdr_t   result
);

	phase_t      phase_q, phase_d;
	logic [31:0] window_q, window_d;
	logic [31:0] len_q, len_d;
	logic [LEN_CNT_W-1:0] len_cnt_q, len_cnt_d;
	logic [31:0] skip_q, skip_d;
	logic [7:0]  units_q, units_d;

	logic        limit_on;
	logic        limit_hit;
	logic [7:0]  units_inc;
	logic [31:0] skip_dec;

	assign limit_on  = (nal_limit != 8'd0);
	assign limit_hit = limit_on && (units_q >= nal_limit);
	assign units_inc = (units_q < UNITS_MAX) ? units_q + 8'd1 : units_q;
	assign skip_dec  = (skip_q != 32'd0) ? skip_q - 32'd1 : 32'd0;

	// next state
	always_comb begin
		phase_d   = phase_q;
		window_d  = window_q;
		len_d     = len_q;
		len_cnt_d = len_cnt_q;
		skip_d    = skip_q;
		units_d   = units_q;
		case (phase_q)
			PH_SEARCH: begin
				window_d = {window_q[23:0], data_byte};
				if (window_d == MARKER_MDAT) begin
					len_d     = 32'd0;
					len_cnt_d = '0;
					phase_d   = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				len_d = {len_q[23:0], data_byte};
				if (len_cnt_q == LEN_CNT_LAST) begin
					len_cnt_d = '0;
					phase_d   = PH_HEADER;
				end else begin
					len_cnt_d = len_cnt_q + 1'b1;
				end
			end
			PH_HEADER: begin
				if (limit_hit) begin
					phase_d = PH_IDLE;
				end else begin
					units_d = units_inc;
					if (limit_on && (units_inc >= nal_limit)) begin
						phase_d = PH_IDLE;
					end else if (len_q >= 32'd2) begin
						skip_d  = len_q - 32'd1;
						phase_d = PH_SKIP;
					end else begin
						len_d     = 32'd0;
						len_cnt_d = '0;
						phase_d   = PH_LENGTH;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 32'd0) begin
					len_d     = 32'd0;
					len_cnt_d = '0;
					phase_d   = PH_LENGTH;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		emit                 = 1'b0;
		result.nal_length    = len_q;
		result.forbidden_bit = data_byte[7];
		result.ref_idc       = data_byte[6:5];
		result.unit_type     = data_byte[4:0];
		case (phase_q)
			PH_HEADER: emit = !limit_hit;
			default:   emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEARCH;
			window_q  <= 32'd0;
			len_q     <= 32'd0;
			len_cnt_q <= '0;
			skip_q    <= 32'd0;
			units_q   <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			window_q  <= window_d;
			len_q     <= len_d;
			len_cnt_q <= len_cnt_d;
			skip_q    <= skip_d;
			units_q   <= units_d;
		end
	end

endmodule

### rtl/mnhp_checker.sv
module mnhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_ready,
	input logic        hdr_valid,
	input logic        hdr_ready,
	input logic [31:0] hdr_nal_length,
	input logic        hdr_forbidden_bit,
	input logic [1:0]  hdr_ref_idc,
	input logic [4:0]  hdr_unit_type
);

	logic byte_acc;
	assign byte_acc = byte_valid && byte_ready;

	// pending word is held until taken
	a_hdr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_ready |=> hdr_valid)
		else $error("hdr word dropped while stalled");

	a_hdr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_ready |=> $stable(hdr_nal_length) && $stable(hdr_forbidden_bit)
			&& $stable(hdr_ref_idc) && $stable(hdr_unit_type))
		else $error("hdr payload changed while stalled");

	// input side never blocks while the output register is empty
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!hdr_valid |-> byte_ready)
		else $error("byte channel stalled with empty output");

	// a fresh word comes from a byte taken earlier through the input register
	a_word_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hdr_valid) |-> $past(byte_acc, 2))
		else $error("hdr word without a matching byte");

endmodule

bind mdat_nal_unit_header_parser_top mnhp_checker u_mnhp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.byte_valid        (byte_ch.valid),
	.byte_ready        (byte_ch.ready),
	.hdr_valid         (hdr_ch.valid),
	.hdr_ready         (hdr_ch.ready),
	.hdr_nal_length    (hdr_ch.nal_length),
	.hdr_forbidden_bit (hdr_ch.forbidden_bit),
	.hdr_ref_idc       (hdr_ch.ref_idc),
	.hdr_unit_type     (hdr_ch.unit_type)
);

### verif/mdat_nal_unit_header_parser_top_test.sv
module mdat_nal_unit_header_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mnhp_pkg::*;

	// generous bound for the timeout check
	localparam int CYCLE_LIMIT = 400000;
	// header word passes the input and output registers after its byte is taken; pad a little
	localparam int DRAIN_PAD = 4;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [7:0] cfg_wr_data;

	mnhp_byte_if byte_ch();
	mnhp_hdr_if hdr_ch();

	mdat_nal_unit_header_parser_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.byte_ch    (byte_ch),
		.hdr_ch     (hdr_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// stream bytes waiting to be offered, header words waiting to be seen
	logic [7:0] byte_pend_q[$];
	nal_hdr_t hdr_expect_q[$];

	// knobs, written by the stimulus block at clock edges
	int idle_pct;
	int stall_pct;
	logic rx_hold;

	int err_cnt;
	int cycle_cnt;

	// ---------------------------------------------------------------
	// Parser mirror: tracks what the block should be doing byte by byte
	// ---------------------------------------------------------------
	logic [31:0] mk_window;
	phase_t ph;
	logic [31:0] len_acc;
	int len_cnt;
	logic [31:0] skip_left;
	logic [7:0] units_cnt;
	logic [7:0] limit_reg;

	function automatic bit limit_hit();
		return limit_reg != 8'd0 && units_cnt >= limit_reg;
	endfunction

	function automatic void open_length();
		len_acc = '0;
		len_cnt = 0;
		ph = PH_LENGTH;
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		nal_hdr_t w;
		case (ph)
			PH_SEARCH: begin
				mk_window = {mk_window[23:0], b};
				if (mk_window == MARKER_MDAT)
					open_length();
			end
			PH_LENGTH: begin
				len_acc = {len_acc[23:0], b};
				if (len_cnt + 1 >= LENGTH_FIELD_BYTES) begin
					len_cnt = 0;
					ph = PH_HEADER;
				end else begin
					len_cnt = len_cnt + 1;
				end
			end
			PH_HEADER: begin
				// a limit lowered to or under the running count: drop straight to idle
				if (limit_hit()) begin
					ph = PH_IDLE;
				end else begin
					w.nal_length = len_acc;
					w.forbidden_bit = b[7];
					w.ref_idc = b[6:5];
					w.unit_type = b[4:0];
					hdr_expect_q.push_back(w);
					if (units_cnt != UNITS_MAX)
						units_cnt = units_cnt + 8'd1;
					if (limit_hit()) begin
						ph = PH_IDLE;
					end else if (len_acc >= 32'd2) begin
						skip_left = len_acc - 32'd1;
						ph = PH_SKIP;
					end else begin
						open_length();
					end
				end
			end
			PH_SKIP: begin
				if (skip_left != 32'd0)
					skip_left = skip_left - 32'd1;
				if (skip_left == 32'd0)
					open_length();
			end
			default: ph = PH_IDLE;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic check_header();
		nal_hdr_t want;
		if (hdr_expect_q.size() == 0) begin
			report_mismatch("header word with none expected", hdr_ch.nal_length, '0);
			return;
		end
		want = hdr_expect_q.pop_front();
		if (hdr_ch.nal_length !== want.nal_length)
			report_mismatch("nal_length", hdr_ch.nal_length, want.nal_length);
		if (hdr_ch.forbidden_bit !== want.forbidden_bit)
			report_mismatch("forbidden_bit", hdr_ch.forbidden_bit, want.forbidden_bit);
		if (hdr_ch.ref_idc !== want.ref_idc)
			report_mismatch("ref_idc", hdr_ch.ref_idc, want.ref_idc);
		if (hdr_ch.unit_type !== want.unit_type)
			report_mismatch("unit_type", hdr_ch.unit_type, want.unit_type);
	endtask

	// ---------------------------------------------------------------
	// Byte driver: a taken word goes through the mirror at the same edge,
	// so expectations exist before the header word can come out.
	// valid only drops or moves on when the slot is free (idle or taken).
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				parse_byte(byte_ch.data_byte);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (byte_pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					byte_ch.valid <= 1'b1;
					byte_ch.data_byte <= byte_pend_q.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Header monitor: checks each taken word, throttles ready
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hdr_ch.valid && hdr_ch.ready)
				check_header();
			hdr_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d header words outstanding",
				cycle_cnt, hdr_expect_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_byte(logic [7:0] b);
		byte_pend_q.push_back(b);
	endtask

	// length prefix, header byte, then, if with_payload is set, the payload the parser will skip
	task automatic push_unit(logic [31:0] len, logic [7:0] hdr, bit with_payload);
		push_byte(len[31:24]);
		push_byte(len[23:16]);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
		push_byte(hdr);
		if (with_payload && len >= 32'd2)
			repeat (len - 1) push_byte(8'($urandom));
	endtask

	// mostly short units, now and then a long skip
	task automatic push_random_units(int n_bytes);
		int stop_at;
		int r;
		logic [31:0] len;
		stop_at = byte_pend_q.size() + n_bytes;
		while (byte_pend_q.size() < stop_at) begin
			r = $urandom_range(99);
			if (r < 20)
				len = $urandom_range(1);
			else if (r < 85)
				len = $urandom_range(8, 2);
			else if (r < 97)
				len = $urandom_range(40, 9);
			else
				len = $urandom_range(300, 256);
			push_unit(len, 8'($urandom), 1'b1);
		end
	endtask

	// block is quiet: nothing queued or offered, no header word owed
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (byte_pend_q.size() != 0 || byte_ch.valid || hdr_expect_q.size() != 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_limit(logic [7:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		limit_reg = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_pace(int idle, int stall);
		@(posedge clk);
		idle_pct <= idle;
		stall_pct <= stall;
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		logic [7:0] lim;

		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		hdr_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		rx_hold = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		err_cnt = 0;
		cycle_cnt = 0;

		mk_window = '0;
		ph = PH_SEARCH;
		len_acc = '0;
		len_cnt = 0;
		skip_left = '0;
		units_cnt = '0;
		limit_reg = 8'd3;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// the reset limit of 3 would park the parser for good; run unlimited
		write_limit(8'd0);

		// Directed: junk and a false start before the marker, then
		// zero and one length units (nothing to skip) with all-zero and
		// all-one headers, then a two byte unit with one payload byte.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte("m");
		push_byte("d");
		push_byte("a");
		push_byte("x");
		push_byte("m");
		push_byte("d");
		push_byte("a");
		push_byte("t");
		push_unit(32'd0, 8'h00, 1'b1);
		push_unit(32'd1, 8'hFF, 1'b1);
		push_unit(32'd2, 8'h65, 1'b1);
		wait_quiet();

		// Receiver holds off while short units keep coming: output register
		// fills, the next header byte parks and byte ready must drop.
		@(posedge clk);
		fork
			begin
				rx_hold <= 1'b1;
				repeat (120) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (30) push_unit($urandom_range(1), 8'($urandom), 1'b1);
		wait_quiet();

		// Random phases, each with its own pace and limit. Limits stay
		// clear of the running count so the parser keeps going.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: lim = 8'd255;
				1: lim = (units_cnt <= 8'd195) ? 8'($urandom_range(255, units_cnt + 60)) : 8'd0;
				default: lim = 8'd0;
			endcase
			write_limit(lim);
			case (p)
				0: set_pace(0, 0);
				1: set_pace(59, 0);
				2: set_pace(0, 59);
				default: set_pace(8, 8);
			endcase
			push_random_units(90);
			wait_quiet();
		end

		// Ending: the parser idles until reset, so only one way in per run.
		if ($urandom_range(1) == 1 && units_cnt < 8'd250) begin
			// limit reached on the second unit; its huge length is never skipped
			write_limit(units_cnt + 8'd2);
			push_unit(32'd1, 8'($urandom), 1'b1);
			push_unit(32'hFFFF_FFFF, 8'($urandom), 1'b0);
			repeat (20) push_byte(8'($urandom));
		end else begin
			// limit dropped to the running count: next header gives no word, idle
			write_limit(units_cnt);
			push_unit(32'd2, 8'($urandom), 1'b1);
			repeat (20) push_byte(8'($urandom));
		end
		wait_quiet();

		// rewriting the limit while idle must not wake the parser
		write_limit(8'd0);
		push_unit(32'd3, 8'($urandom), 1'b1);
		push_unit(32'd0, 8'($urandom), 1'b1);
		wait_quiet();

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### mdat_nal_unit_header_parser_top.f
rtl/mnhp_pkg.sv
rtl/mnhp_ifs.sv
rtl/mnhp_parser.sv
rtl/mdat_nal_unit_header_parser_top.sv
rtl/mnhp_checker.sv
verif/mdat_nal_unit_header_parser_top_test.sv
